### src/tile_background_slice_renderer_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TILE_BACKGROUND_SLICE_RENDERER_TOP_DEFINES_SVH
`define TILE_BACKGROUND_SLICE_RENDERER_TOP_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define TBSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define TBSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tbsr_pkg.sv
// Shared constants, types and the sequencer program of the tile slice renderer.
package tbsr_pkg;

    localparam int MEM_WORDS          = 65536;
    localparam int MEM_AW             = $clog2(MEM_WORDS);
    localparam int SCREEN_PIXELS_WIDE = 256;

    localparam logic [16:0] MEM_LIMIT    = 17'(MEM_WORDS);
    localparam logic [16:0] PAT_LIMIT    = 17'(MEM_WORDS / 2);
    localparam logic [8:0]  SCREEN_LIMIT = 9'(SCREEN_PIXELS_WIDE);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_DRAW  = 1'b1;

    typedef enum logic [1:0] {
        CFG_PATTERN_BASE,
        CFG_ATTRIBUTE_BASE,
        CFG_SCROLL_H,
        CFG_SCROLL_V
    } t_cfg_reg;

    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE    = 4'd0;
    localparam t_step ST_ATTR_RD = 4'd1;
    localparam t_step ST_ATTR_LD = 4'd2;
    localparam t_step ST_PIDX    = 4'd3;
    localparam t_step ST_CHECK   = 4'd4;
    localparam t_step ST_MODE    = 4'd5;
    localparam t_step ST_HI_RD   = 4'd6;
    localparam t_step ST_LO_RD   = 4'd7;
    localparam t_step ST_LO_LD   = 4'd8;
    localparam t_step ST_EMIT    = 4'd9;
    localparam t_step ST_SW_RD   = 4'd10;
    localparam t_step ST_SW_LD   = 4'd11;
    localparam t_step ST_SW_EMIT = 4'd12;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_ATTR,
        RD_PAT_HI,
        RD_PAT_LO,
        RD_PAT_SWAP
    } t_rd;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_ATTR,
        LD_PIDX,
        LD_OK,
        LD_HI,
        LD_LO,
        LD_SWAP
    } t_ld;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_WAIT_IN,
        BR_BAD,
        BR_SWAP,
        BR_PIXEL
    } t_br;

    typedef struct packed {
        t_rd   rd;
        t_ld   ld;
        logic  emit;
        t_br   br;
        t_step target;
    } t_ucode;

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode w;
        w = '{rd: RD_NONE, ld: LD_NONE, emit: 1'b0, br: BR_NEXT, target: ST_IDLE};
        unique case (step)
            ST_IDLE:    w.br = BR_WAIT_IN;
            ST_ATTR_RD: w.rd = RD_ATTR;
            ST_ATTR_LD: w.ld = LD_ATTR;
            ST_PIDX:    w.ld = LD_PIDX;
            ST_CHECK: begin
                w.ld     = LD_OK;
                w.br     = BR_BAD;
                w.target = ST_EMIT;     // bad fetch: emit 8 blank pixels
            end
            ST_MODE: begin
                w.br     = BR_SWAP;
                w.target = ST_SW_RD;
            end
            ST_HI_RD:   w.rd = RD_PAT_HI;
            ST_LO_RD: begin
                w.ld = LD_HI;
                w.rd = RD_PAT_LO;
            end
            ST_LO_LD:   w.ld = LD_LO;
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.br     = BR_PIXEL;
                w.target = ST_EMIT;
            end
            ST_SW_RD:   w.rd = RD_PAT_SWAP;
            ST_SW_LD:   w.ld = LD_SWAP;
            ST_SW_EMIT: begin
                w.emit   = 1'b1;
                w.br     = BR_PIXEL;
                w.target = ST_SW_RD;
            end
            default: begin
                w.br     = BR_PIXEL;    // unused steps fall back to idle
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### src/tbsr_ram.sv
// Generic single-port RAM with registered read data.
module tbsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/tile_background_slice_renderer_top.sv
// Top level: microcoded tile column renderer over a single-port video memory.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall    | req_type, mem_address, mem_data, line, column
//  output   | o_out_valid / i_out_stall  | pixel_x, palette_index, visible, last_pixel
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A memory write is taken while the sequencer is idle. A draw of a plain tile row
// does an attribute read, two pattern reads, then one pixel a cycle while the
// output is not stalled; a swapped row does one pattern read per pixel, 3 steps
// each, and a fetch out of bounds emits blank pixels. Output stalls hold the
// sequencer on its emit step. Reset is synchronous and clears config, step
// counter and output valid; video memory is not cleared.
module tile_background_slice_renderer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_mem_address,
    input  logic [15:0] i_mem_data,
    input  logic [7:0]  i_line_number,
    input  logic [4:0]  i_tile_column,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_x,
    output logic [5:0]  o_palette_index,
    output logic        o_visible,
    output logic        o_last_pixel,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [14:0] r_pattern_base;
    logic [15:0] r_attribute_base;
    logic [7:0]  r_scroll_h;
    logic [7:0]  r_scroll_v;

    // sequencer
    tbsr_pkg::t_step  r_step;
    tbsr_pkg::t_step  n_step;
    tbsr_pkg::t_ucode ctrl;
    logic [2:0]       r_pix;
    logic             in_acc;
    logic             out_free;
    logic             emit_go;

    // datapath
    logic [2:0]  r_src_row;
    logic [4:0]  r_column;
    logic [16:0] r_attr_addr;
    logic [15:0] r_attr;
    logic [15:0] r_pidx;
    logic        r_ok;
    logic [15:0] r_word_hi;
    logic [15:0] r_word_lo;
    logic [15:0] r_word_sw;

    logic [7:0]  src_line;
    logic [15:0] attr_row_base;
    logic        attr_ok;
    logic        pat_ok;
    logic [2:0]  pat_row;
    logic [2:0]  nib_pos;
    logic [15:0] sel_word;
    logic [1:0]  sel_shift;
    logic [3:0]  nib;
    logic [7:0]  pix_x;
    logic        pix_vis;

    // memory port
    logic                        ram_we;
    logic [tbsr_pkg::MEM_AW-1:0] ram_addr;
    logic [16:0]                 pat_addr;
    logic [15:0]                 ram_rdata;

    tbsr_ram #(
        .WIDTH (16),
        .DEPTH (tbsr_pkg::MEM_WORDS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_mem_data),
        .o_rdata (ram_rdata)
    );

    assign ctrl       = tbsr_pkg::ucode_rom(r_step);
    assign o_in_stall = (r_step != tbsr_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && (r_step == tbsr_pkg::ST_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;
    assign emit_go    = ctrl.emit && out_free;

    assign ram_we = in_acc && (i_req_type == tbsr_pkg::REQ_WRITE)
                    && ({1'b0, i_mem_address} < tbsr_pkg::MEM_LIMIT);

    assign src_line      = i_line_number - r_scroll_v;
    assign attr_row_base = r_attribute_base + {6'b0, src_line[7:3], 5'b0};

    assign attr_ok = (r_attr_addr < tbsr_pkg::MEM_LIMIT);
    assign pat_row = r_attr[2] ? ~r_src_row : r_src_row;
    assign pat_ok  = attr_ok
                     && (({1'b0, r_pidx} + 17'd1) < tbsr_pkg::PAT_LIMIT)
                     && !(r_attr[1] && (({1'b0, r_pidx} + 17'd8) >= tbsr_pkg::PAT_LIMIT));

    // nibble position within the row: x flip walks left to right
    assign nib_pos = r_attr[3] ? r_pix : ~r_pix;

    always_comb begin
        unique case (ctrl.rd)
            tbsr_pkg::RD_ATTR:     pat_addr = r_attr_addr;
            tbsr_pkg::RD_PAT_HI:   pat_addr = {r_pidx, 1'b1};
            tbsr_pkg::RD_PAT_LO:   pat_addr = {r_pidx, 1'b0};
            tbsr_pkg::RD_PAT_SWAP: pat_addr = {r_pidx[15:3], nib_pos, ~r_pidx[2]};
            default:               pat_addr = {1'b0, i_mem_address};
        endcase
        ram_addr = pat_addr[tbsr_pkg::MEM_AW-1:0];
    end

    always_comb begin
        if (r_attr[1]) begin
            sel_word  = r_word_sw;
            sel_shift = r_pidx[1:0];
        end else begin
            sel_word  = nib_pos[2] ? r_word_lo : r_word_hi;
            sel_shift = nib_pos[1:0];
        end
        nib     = 4'(sel_word >> {sel_shift, 2'b00});
        pix_x   = {r_column, 3'b000} + r_scroll_h + {5'b0, r_pix};
        pix_vis = r_ok && !nib[3] && ({1'b0, pix_x} < tbsr_pkg::SCREEN_LIMIT);
    end

    always_comb begin
        unique case (ctrl.br)
            tbsr_pkg::BR_NEXT:
                n_step = r_step + 4'd1;
            tbsr_pkg::BR_WAIT_IN:
                n_step = (in_acc && (i_req_type == tbsr_pkg::REQ_DRAW))
                         ? r_step + 4'd1 : r_step;
            tbsr_pkg::BR_BAD:
                n_step = pat_ok ? r_step + 4'd1 : ctrl.target;
            tbsr_pkg::BR_SWAP:
                n_step = r_attr[1] ? ctrl.target : r_step + 4'd1;
            tbsr_pkg::BR_PIXEL: begin
                if (ctrl.emit && !out_free) begin
                    n_step = r_step;
                end else if (r_pix != 3'd7) begin
                    n_step = ctrl.target;
                end else begin
                    n_step = tbsr_pkg::ST_IDLE;
                end
            end
            default:
                n_step = tbsr_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step           <= tbsr_pkg::ST_IDLE;
            r_pix            <= 3'd0;
            o_out_valid      <= 1'b0;
            r_pattern_base   <= '0;
            r_attribute_base <= '0;
            r_scroll_h       <= '0;
            r_scroll_v       <= '0;
        end else begin
            r_step <= n_step;
            if (in_acc) begin
                r_pix <= 3'd0;
            end else if (emit_go) begin
                r_pix <= r_pix + 3'd1;
            end
            if (emit_go) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (tbsr_pkg::t_cfg_reg'(i_cfg_index))
                    tbsr_pkg::CFG_PATTERN_BASE:   r_pattern_base   <= i_cfg_data[14:0];
                    tbsr_pkg::CFG_ATTRIBUTE_BASE: r_attribute_base <= i_cfg_data;
                    tbsr_pkg::CFG_SCROLL_H:       r_scroll_h       <= i_cfg_data[7:0];
                    tbsr_pkg::CFG_SCROLL_V:       r_scroll_v       <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_src_row   <= src_line[2:0];
            r_column    <= i_tile_column;
            r_attr_addr <= {1'b0, attr_row_base} + {12'b0, i_tile_column};
        end
        unique case (ctrl.ld)
            tbsr_pkg::LD_ATTR: r_attr    <= attr_ok ? ram_rdata : 16'h0000;
            tbsr_pkg::LD_PIDX: r_pidx    <= ({1'b0, r_pattern_base} + {5'b0, r_attr[15:8], 3'b000})
                                            | {13'b0, pat_row};
            tbsr_pkg::LD_OK:   r_ok      <= pat_ok;
            tbsr_pkg::LD_HI:   r_word_hi <= ram_rdata;
            tbsr_pkg::LD_LO:   r_word_lo <= ram_rdata;
            tbsr_pkg::LD_SWAP: r_word_sw <= ram_rdata;
            default: ;
        endcase
        if (emit_go) begin
            o_pixel_x       <= pix_x;
            o_palette_index <= pix_vis ? {r_attr[6:4], nib[2:0]} : 6'd0;
            o_visible       <= pix_vis;
            o_last_pixel    <= (r_pix == 3'd7);
        end
    end

endmodule

### src/tbsr_checker.sv
// Port-level checks for the tile slice renderer, bound to its top level.
`include "tile_background_slice_renderer_top_defines.svh"

module tbsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_req_type,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_pixel_x,
    input logic [5:0] o_palette_index,
    input logic       o_visible,
    input logic       o_last_pixel
);

    // a stalled pixel transaction holds its value
    `TBSR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x) && $stable(o_palette_index) && $stable(o_last_pixel), "output changed while stalled")

    // a draw keeps the input side busy until its pixels are out
    `TBSR_ASSERT(a_draw_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_req_type |=> o_in_stall, "input taken during a draw")

    // a column still in flight blocks new input
    `TBSR_ASSERT(a_mid_column, i_clk, i_rst_n, o_out_valid && !o_last_pixel |-> o_in_stall, "idle before the eighth pixel")

    `TBSR_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind tile_background_slice_renderer_top tbsr_checker u_tbsr_checker (.*);
